// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define CRKS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// checked on every edge, reset included
`define CRKS_ASSERT_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");

`endif

// File: hw/rtl/crks_pkg.sv
// ----------------------------------------------------------------------------
// crks_pkg
// types, constants and arithmetic helpers of the reaction kinetics step unit
// ----------------------------------------------------------------------------
`default_nettype none

package crks_pkg;

  localparam int unsigned MaxCells = 1024;
  localparam int unsigned CellIdxW = $clog2(MaxCells);
  localparam int unsigned LvlW     = 24;
  localparam int unsigned TsW      = 16;
  localparam int unsigned ProdW    = 32;
  localparam int unsigned DenW     = 33;
  localparam int unsigned QuoW     = 32;
  localparam int unsigned RateW    = 34;
  localparam int unsigned MulW     = RateW + TsW + 1;
  localparam int unsigned AccW     = MulW + 1;
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned OneQ16   = 65536;

  typedef enum logic [2:0] {
    RegActGain    = 3'd0,
    RegInhGain    = 3'd1,
    RegDecayRate  = 3'd2,
    RegTimeStep   = 3'd3,
    RegInhThresh  = 3'd4,
    RegSec1Thresh = 3'd5,
    RegSec1Rate   = 3'd6,
    RegSec2Inhib  = 3'd7
  } crks_reg_e;

  typedef logic [LvlW-1:0]         lvl_t;
  typedef logic [ProdW-1:0]        prod_t;
  typedef logic signed [RateW-1:0] rate_t;
  typedef logic signed [MulW-1:0]  mul_t;

  typedef struct packed {
    lvl_t act;
    lvl_t inh;
    lvl_t sec1;
    lvl_t sec2;
  } levels_t;

  typedef struct packed {
    logic [CellIdxW-1:0] idx;
    levels_t             lv;
    lvl_t                diff;
    logic                centre;
  } stg_a_t;

  typedef struct packed {
    levels_t lv;
    logic    knot;
    prod_t   ag_a;
    prod_t   ig_i;
    prod_t   m_a;
    prod_t   a_d;
    prod_t   m_i;
    prod_t   sr_d;
    prod_t   m_s1;
    prod_t   m_s2;
    prod_t   si_s1;
    logic    d_gt_inh;
    logic    d_gt_s1;
  } stg_b_t;

  typedef struct packed {
    levels_t         lv;
    logic            knot;
    prod_t           m_a;
    rate_t           r_inh;
    rate_t           r_s1;
    rate_t           r_s2;
    logic [DenW-1:0] den;
    logic [DenW-1:0] rem;
    logic [QuoW-1:0] num;
    logic [QuoW-1:0] quo;
  } stg_div_t;

  typedef struct packed {
    levels_t lv;
    logic    knot;
    rate_t   r_act;
    rate_t   r_inh;
    rate_t   r_s1;
    rate_t   r_s2;
  } stg_e_t;

  typedef struct packed {
    levels_t lv;
    logic    knot;
    mul_t    p_act;
    mul_t    p_inh;
    mul_t    p_s1;
    mul_t    p_s2;
  } stg_f_t;

  typedef struct packed {
    levels_t lv;
    logic    knot;
  } stg_o_t;

  // floored q8.16 product
  function automatic prod_t qmul(lvl_t x, lvl_t y);
    logic [2*LvlW-1:0] p;
    p = x * y;
    return p[2*LvlW-1:16];
  endfunction

  // one restoring division step
  function automatic stg_div_t div_step(stg_div_t s);
    stg_div_t      r;
    logic [DenW:0] t;
    logic [DenW:0] diff;
    r    = s;
    t    = {s.rem, s.num[QuoW-1]};
    diff = t - {1'b0, s.den};
    r.num = {s.num[QuoW-2:0], 1'b0};
    if (t >= {1'b0, s.den}) begin
      r.rem = diff[DenW-1:0];
      r.quo = {s.quo[QuoW-2:0], 1'b1};
    end else begin
      r.rem = t[DenW-1:0];
      r.quo = {s.quo[QuoW-2:0], 1'b0};
    end
    return r;
  endfunction

  // level plus scaled rate, clamped at zero and saturated
  function automatic lvl_t advance(lvl_t lvl, mul_t p);
    logic signed [AccW-1:0] acc;
    lvl_t                   r;
    acc = $signed({{(AccW-LvlW-16){1'b0}}, lvl, 16'b0}) + $signed({p[MulW-1], p});
    if (acc[AccW-1]) begin
      r = '0;
    end else if (|acc[AccW-2:LvlW+16]) begin
      r = '1;
    end else begin
      r = acc[LvlW+15:16];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/crks_ram.sv
// ----------------------------------------------------------------------------
// crks_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module crks_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/cell_reaction_kinetics_step_unit.sv
// ----------------------------------------------------------------------------
// cell_reaction_kinetics_step_unit
// one explicit reaction step of a cell's four epithelial protein levels
// ----------------------------------------------------------------------------
// The unit takes one cell beat per clock while in_stall_o is low and returns
// one result beat per cell, in order. The 32-stage restoring divider forms
// the activator rate; per-cell knot flags live in a 1024 x 1 ram that is read
// on acceptance and written back from the a stage as the beat moves on, with
// a one-deep forward of the last write. After reset the flag ram is cleared
// cell by cell, during which in_stall_o stays high; configuration writes are
// taken at any time.
`default_nettype none

`include "assert_macros.svh"

module cell_reaction_kinetics_step_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire crks_pkg::crks_reg_e         cfg_index_i,
  input  wire logic [crks_pkg::LvlW-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [crks_pkg::CellIdxW-1:0] cell_index_i,
  input  wire logic [crks_pkg::LvlW-1:0]   act_level_i,
  input  wire logic [crks_pkg::LvlW-1:0]   inh_level_i,
  input  wire logic [crks_pkg::LvlW-1:0]   sec1_level_i,
  input  wire logic [crks_pkg::LvlW-1:0]   sec2_level_i,
  input  wire logic [crks_pkg::LvlW-1:0]   diff_level_i,
  input  wire logic                        in_centre_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [crks_pkg::LvlW-1:0]        new_act_o,
  output logic [crks_pkg::LvlW-1:0]        new_inh_o,
  output logic [crks_pkg::LvlW-1:0]        new_sec1_o,
  output logic [crks_pkg::LvlW-1:0]        new_sec2_o,
  output logic                             is_knot_o
);

  import crks_pkg::*;

  lvl_t             act_gain_q, inh_gain_q, decay_rate_q;
  logic [TsW-1:0]   time_step_q;
  lvl_t             inh_thresh_q, sec1_thresh_q, sec1_rate_q, sec2_inhib_q;

  logic                clr_busy_q;
  logic [CellIdxW-1:0] clr_cnt_q;

  logic                fwd_vld_q;
  logic [CellIdxW-1:0] fwd_idx_q;

  logic en, accept, set_now, knot_a, ram_rdata;
  logic                ram_we, ram_wdata;
  logic [CellIdxW-1:0] ram_waddr, ram_raddr;

  stg_a_t   a_q, a_d;
  stg_b_t   b_q, b_d;
  stg_div_t dv_q [DivSteps+1];
  stg_div_t dv_d [DivSteps+1];
  stg_e_t   e_q, e_d;
  stg_f_t   f_q, f_d;
  stg_o_t   o_q, o_d;
  logic     a_vq, b_vq, e_vq, f_vq, out_vq;
  logic [DivSteps:0] dv_vq;

  prod_t              pos;
  rate_t              r_s1_w, r_s2_w;
  logic signed [TsW:0] ts_s;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_gain_q    <= LvlW'(65536);
      inh_gain_q    <= LvlW'(65536);
      decay_rate_q  <= LvlW'(6554);
      time_step_q   <= TsW'(328);
      inh_thresh_q  <= LvlW'(65536);
      sec1_thresh_q <= LvlW'(65536);
      sec1_rate_q   <= LvlW'(65536);
      sec2_inhib_q  <= LvlW'(65536);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegActGain:    act_gain_q    <= cfg_data_i;
        RegInhGain:    inh_gain_q    <= cfg_data_i;
        RegDecayRate:  decay_rate_q  <= cfg_data_i;
        RegTimeStep:   time_step_q   <= cfg_data_i[TsW-1:0];
        RegInhThresh:  inh_thresh_q  <= cfg_data_i;
        RegSec1Thresh: sec1_thresh_q <= cfg_data_i;
        RegSec1Rate:   sec1_rate_q   <= cfg_data_i;
        RegSec2Inhib:  sec2_inhib_q  <= cfg_data_i;
      endcase
    end
  end

  // handshake
  assign en         = !out_vq || !out_stall_i;
  assign in_stall_o = !en || clr_busy_q;
  assign accept     = in_valid_i && !in_stall_o;

  // knot flag store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == CellIdxW'(MaxCells - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign set_now   = (a_q.lv.act > LvlW'(OneQ16)) && a_q.centre;
  assign knot_a    = ram_rdata || set_now || (fwd_vld_q && (fwd_idx_q == a_q.idx));
  assign ram_raddr = en ? cell_index_i : a_q.idx;
  assign ram_we    = clr_busy_q || (en && a_vq && set_now);
  assign ram_waddr = clr_busy_q ? clr_cnt_q : a_q.idx;
  assign ram_wdata = !clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (en) begin
      fwd_vld_q <= a_vq && set_now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_idx_q <= a_q.idx;
    end
  end

  crks_ram #(
    .Width (1),
    .Depth (MaxCells)
  ) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // datapath
  always_comb begin
    a_d.idx     = cell_index_i;
    a_d.lv.act  = act_level_i;
    a_d.lv.inh  = inh_level_i;
    a_d.lv.sec1 = sec1_level_i;
    a_d.lv.sec2 = sec2_level_i;
    a_d.diff    = diff_level_i;
    a_d.centre  = in_centre_i;
  end

  always_comb begin
    b_d.lv       = a_q.lv;
    b_d.knot     = knot_a;
    b_d.ag_a     = qmul(act_gain_q, a_q.lv.act);
    b_d.ig_i     = qmul(inh_gain_q, a_q.lv.inh);
    b_d.m_a      = qmul(decay_rate_q, a_q.lv.act);
    b_d.a_d      = qmul(a_q.lv.act, a_q.diff);
    b_d.m_i      = qmul(decay_rate_q, a_q.lv.inh);
    b_d.sr_d     = qmul(sec1_rate_q, a_q.diff);
    b_d.m_s1     = qmul(decay_rate_q, a_q.lv.sec1);
    b_d.m_s2     = qmul(decay_rate_q, a_q.lv.sec2);
    b_d.si_s1    = qmul(sec2_inhib_q, a_q.lv.sec1);
    b_d.d_gt_inh = a_q.diff > inh_thresh_q;
    b_d.d_gt_s1  = a_q.diff > sec1_thresh_q;
  end

  always_comb begin
    pos = (b_q.ag_a > {{(ProdW-LvlW){1'b0}}, b_q.lv.sec2})
        ? b_q.ag_a - {{(ProdW-LvlW){1'b0}}, b_q.lv.sec2} : '0;
    dv_d[0].lv   = b_q.lv;
    dv_d[0].knot = b_q.knot;
    dv_d[0].m_a  = b_q.m_a;
    if (b_q.d_gt_inh) begin
      dv_d[0].r_inh = $signed({2'b00, b_q.a_d}) - $signed({2'b00, b_q.m_i});
    end else if (b_q.knot) begin
      dv_d[0].r_inh = $signed({{(RateW-LvlW){1'b0}}, b_q.lv.act})
                    - $signed({2'b00, b_q.m_i});
    end else begin
      dv_d[0].r_inh = '0;
    end
    if (b_q.d_gt_s1) begin
      r_s1_w = $signed({2'b00, b_q.sr_d}) - $signed({2'b00, b_q.m_s1});
    end else if (b_q.knot) begin
      r_s1_w = $signed({{(RateW-LvlW){1'b0}}, sec1_rate_q}) - $signed({2'b00, b_q.m_s1});
    end else begin
      r_s1_w = '0;
    end
    dv_d[0].r_s1 = r_s1_w[RateW-1] ? '0 : r_s1_w;
    r_s2_w = $signed({2'b00, b_q.ag_a}) - $signed({2'b00, b_q.m_s2})
           - $signed({2'b00, b_q.si_s1});
    dv_d[0].r_s2 = r_s2_w[RateW-1] ? '0 : r_s2_w;
    dv_d[0].den  = DenW'(OneQ16) + {1'b0, b_q.ig_i};
    dv_d[0].rem  = {{(DenW-16){1'b0}}, pos[ProdW-1:16]};
    dv_d[0].num  = {pos[15:0], 16'b0};
    dv_d[0].quo  = '0;
    for (int k = 1; k <= DivSteps; k++) begin
      dv_d[k] = div_step(dv_q[k-1]);
    end
  end

  assign ts_s = $signed({1'b0, time_step_q});

  always_comb begin
    e_d.lv    = dv_q[DivSteps].lv;
    e_d.knot  = dv_q[DivSteps].knot;
    e_d.r_act = $signed({2'b00, dv_q[DivSteps].quo}) - $signed({2'b00, dv_q[DivSteps].m_a});
    e_d.r_inh = dv_q[DivSteps].r_inh;
    e_d.r_s1  = dv_q[DivSteps].r_s1;
    e_d.r_s2  = dv_q[DivSteps].r_s2;

    f_d.lv    = e_q.lv;
    f_d.knot  = e_q.knot;
    f_d.p_act = e_q.r_act * ts_s;
    f_d.p_inh = e_q.r_inh * ts_s;
    f_d.p_s1  = e_q.r_s1 * ts_s;
    f_d.p_s2  = e_q.r_s2 * ts_s;

    o_d.lv.act  = advance(f_q.lv.act, f_q.p_act);
    o_d.lv.inh  = advance(f_q.lv.inh, f_q.p_inh);
    o_d.lv.sec1 = advance(f_q.lv.sec1, f_q.p_s1);
    o_d.lv.sec2 = advance(f_q.lv.sec2, f_q.p_s2);
    o_d.knot    = f_q.knot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vq   <= 1'b0;
      b_vq   <= 1'b0;
      dv_vq  <= '0;
      e_vq   <= 1'b0;
      f_vq   <= 1'b0;
      out_vq <= 1'b0;
    end else if (en) begin
      a_vq   <= accept;
      b_vq   <= a_vq;
      dv_vq  <= {dv_vq[DivSteps-1:0], b_vq};
      e_vq   <= dv_vq[DivSteps];
      f_vq   <= e_vq;
      out_vq <= f_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= b_d;
      for (int k = 0; k <= DivSteps; k++) begin
        dv_q[k] <= dv_d[k];
      end
      e_q <= e_d;
      f_q <= f_d;
      o_q <= o_d;
    end
  end

  assign out_valid_o = out_vq;
  assign new_act_o   = o_q.lv.act;
  assign new_inh_o   = o_q.lv.inh;
  assign new_sec1_o  = o_q.lv.sec1;
  assign new_sec2_o  = o_q.lv.sec2;
  assign is_knot_o   = o_q.knot;

  // checks
  `CRKS_ASSERT_ALL(a_reset_quiet, !rst_ni |=> !out_valid_o && in_stall_o)
  `CRKS_ASSERT(a_clear_idle, clr_busy_q |-> !a_vq && !out_vq)
  `CRKS_ASSERT(a_knot_carried, en && a_vq && set_now |=> b_vq && b_q.knot)
  `CRKS_ASSERT(a_div_rem, dv_vq[DivSteps] |-> dv_q[DivSteps].rem < dv_q[DivSteps].den)

endmodule

`default_nettype wire

// File: test/tb_cell_reaction_kinetics_step_unit.sv
// ----------------------------------------------------------------------------
// tb_cell_reaction_kinetics_step_unit
// streams cells through the reaction step unit under several register
// settings, with random gaps and output stalls, and checks every result
// against an in-bench prediction of the four levels and the knot flag
// ----------------------------------------------------------------------------
`default_nettype none

class kinetics_scoreboard;
  logic [23:0] act_gain, inh_gain, decay_rate, inh_thr, sec1_thr, sec1_rate, sec2_inh;
  logic [15:0] time_step;
  bit          knot_flags[1024];
  logic [96:0] pending_levels[$];
  int          errors;

  function new();
    act_gain = 65536; inh_gain = 65536; decay_rate = 6554; time_step = 328;
    inh_thr = 65536; sec1_thr = 65536; sec1_rate = 65536; sec2_inh = 65536;
    errors = 0;
  endfunction

  function void write_reg(crks_pkg::crks_reg_e idx, logic [23:0] v);
    case (idx)
      crks_pkg::RegActGain:    act_gain = v;
      crks_pkg::RegInhGain:    inh_gain = v;
      crks_pkg::RegDecayRate:  decay_rate = v;
      crks_pkg::RegTimeStep:   time_step = v[15:0];
      crks_pkg::RegInhThresh:  inh_thr = v;
      crks_pkg::RegSec1Thresh: sec1_thr = v;
      crks_pkg::RegSec1Rate:   sec1_rate = v;
      crks_pkg::RegSec2Inhib:  sec2_inh = v;
      default: ;
    endcase
  endfunction

  function longint fmul(longint x, longint y);
    return (x * y) >>> 16;
  endfunction

  function logic [23:0] integrate(longint lvl, longint rate);
    longint acc;
    acc = (lvl <<< 16) + longint'(time_step) * rate;
    if (acc < 0) return 0;
    acc = acc >>> 16;
    return acc > 64'hFFFFFF ? 24'hFFFFFF : acc[23:0];
  endfunction

  function void note_cell(logic [9:0] idx, logic [23:0] a, i, s1, s2, d, logic centre);
    longint pos, den, r_act, r_inh, r_s1, r_s2;
    bit     knot;
    if (a > 65536 && centre) knot_flags[idx] = 1;
    knot = knot_flags[idx];
    pos = fmul(act_gain, a) - s2;
    if (pos < 0) pos = 0;
    den = 65536 + fmul(inh_gain, i);
    r_act = (pos <<< 16) / den - fmul(decay_rate, a);
    r_inh = 0;
    if (d > inh_thr) r_inh = fmul(a, d) - fmul(decay_rate, i);
    else if (knot) r_inh = a - fmul(decay_rate, i);
    r_s1 = 0;
    if (d > sec1_thr) r_s1 = fmul(sec1_rate, d) - fmul(decay_rate, s1);
    else if (knot) r_s1 = sec1_rate - fmul(decay_rate, s1);
    if (r_s1 < 0) r_s1 = 0;
    r_s2 = fmul(act_gain, a) - fmul(decay_rate, s2) - fmul(sec2_inh, s1);
    if (r_s2 < 0) r_s2 = 0;
    pending_levels.push_back({integrate(a, r_act), integrate(i, r_inh),
                              integrate(s1, r_s1), integrate(s2, r_s2), knot});
  endfunction

  function void check_result(logic [23:0] a, i, s1, s2, logic k);
    logic [96:0] e;
    if (pending_levels.size() == 0) begin
      $error("result with nothing expected");
      errors++;
      return;
    end
    e = pending_levels.pop_front();
    if (a !== e[96:73]) begin $error("new_act exp %h got %h", e[96:73], a); errors++; end
    if (i !== e[72:49]) begin $error("new_inh exp %h got %h", e[72:49], i); errors++; end
    if (s1 !== e[48:25]) begin $error("new_sec1 exp %h got %h", e[48:25], s1); errors++; end
    if (s2 !== e[24:1]) begin $error("new_sec2 exp %h got %h", e[24:1], s2); errors++; end
    if (k !== e[0]) begin $error("is_knot exp %b got %b", e[0], k); errors++; end
  endfunction
endclass

module tb_cell_reaction_kinetics_step_unit;
  logic clk_i = 0, rst_ni = 0;
  logic cfg_valid_i = 0, cfg_ready_o;
  crks_pkg::crks_reg_e cfg_index_i = crks_pkg::RegActGain;
  logic [23:0] cfg_data_i = 0;
  logic in_valid_i = 0, in_stall_o;
  logic [9:0] cell_index_i = 0;
  logic [23:0] act_level_i = 0, inh_level_i = 0, sec1_level_i = 0, sec2_level_i = 0;
  logic [23:0] diff_level_i = 0;
  logic in_centre_i = 0;
  logic out_valid_o, out_stall_i = 1, is_knot_o;
  logic [23:0] new_act_o, new_inh_o, new_sec1_o, new_sec2_o;
  kinetics_scoreboard sb;
  int cycle_count = 0;
  bit hold_off = 0;
  bit rx_on = 0;

  always #4 clk_i = ~clk_i;

  cell_reaction_kinetics_step_unit u_top (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb_cell_reaction_kinetics_step_unit: errors");
      $finish;
    end
  end

  // output side: a drawn wait after every beat, and a long hold-off on request
  initial begin
    int wait_left;
    wait_left = 0;
    sb = new();
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(new_act_o, new_inh_o, new_sec1_o, new_sec2_o, is_knot_o);
        wait_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 7));
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_stall_i <= !rx_on || hold_off || (wait_left != 0);
    end
  end

  task automatic write_reg(crks_pkg::crks_reg_e idx, logic [23:0] v);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, v);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_cell(logic [9:0] idx, logic [23:0] a, i, s1, s2, d, logic c,
                           bit gaps);
    int gap;
    gap = gaps ? (($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 7))) : 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1; cell_index_i <= idx; act_level_i <= a; inh_level_i <= i;
    sec1_level_i <= s1; sec2_level_i <= s2; diff_level_i <= d; in_centre_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_cell(idx, a, i, s1, s2, d, c);
  endtask

  function automatic logic [23:0] rand_level();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 24'hFFFFFF));
      1: return 24'($urandom_range(0, 24'h3FFFF));
      2: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
      default: return 24'($urandom_range(0, 24'h2FFFF));
    endcase
  endfunction

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending_levels.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic random_cells(int n, bit gaps);
    repeat (n)
      send_cell(10'($urandom_range(0, 63) + (($urandom_range(0, 3) == 0) ? 960 : 0)),
                rand_level(), rand_level(), rand_level(), rand_level(), rand_level(),
                1'($urandom_range(0, 1)), gaps);
  endtask

  task automatic random_config(bit extreme);
    for (int r = 0; r < 8; r++)
      write_reg(crks_pkg::crks_reg_e'(r),
                extreme ? ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h0)
                : ((r == 3) ? 24'($urandom_range(0, 65535)) : rand_level()));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    rx_on = 1;
    // directed: extremes, knot set and not set, thresholds
    send_cell(0, 0, 0, 0, 0, 0, 0, 0);
    send_cell(10'h3FF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 0);
    send_cell(5, 65536, 0, 0, 0, 0, 1, 0);
    send_cell(5, 65537, 0, 0, 0, 0, 1, 0);
    send_cell(5, 0, 100, 100, 100, 0, 0, 0);
    send_cell(6, 24'h20000, 0, 0, 0, 0, 0, 0);
    send_cell(7, 24'h10000, 24'h10000, 24'h10000, 24'h10000, 65537, 0, 0);
    send_cell(7, 24'h10000, 24'h10000, 24'h10000, 24'h10000, 65536, 0, 0);
    send_cell(8, 24'hFFFFFF, 0, 0, 0, 24'hFFFFFF, 0, 0);
    send_cell(9, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 1, 0);
    send_cell(10'h2AA, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1, 0);
    drain();
    write_reg(crks_pkg::RegTimeStep, 24'h00FFFF);
    write_reg(crks_pkg::RegDecayRate, 24'hFFFFFF);
    send_cell(11, 24'h20000, 24'h30000, 24'h40000, 24'h50000, 24'h0, 0, 0);
    send_cell(5, 24'h1000, 24'h30000, 24'h40000, 24'h50000, 24'h0, 0, 0);
    drain();
    random_cells(150, 1);
    drain();
    // long output hold-off so the pipeline backs up into the input
    fork
      begin hold_off = 1; repeat (300) @(posedge clk_i); hold_off = 0; end
      random_cells(100, 0);
    join
    drain();
    random_config(1);
    random_cells(60, 1);
    drain();
    random_config(1);
    random_cells(60, 1);
    drain();
    random_config(0);
    random_cells(120, 1);
    drain();
    random_config(0);
    write_reg(crks_pkg::RegTimeStep, 24'h00FFFF);
    random_cells(140, 1);
    drain();
    if (sb.errors == 0 && sb.pending_levels.size() == 0)
      $display("tb_cell_reaction_kinetics_step_unit: clean");
    else
      $display("tb_cell_reaction_kinetics_step_unit: errors");
    $finish;
  end
endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/crks_pkg.sv
hw/rtl/crks_ram.sv
hw/rtl/cell_reaction_kinetics_step_unit.sv
test/tb_cell_reaction_kinetics_step_unit.sv
